/* rtl/rwl_pkg.sv */
// Shared types and constants for the reader-writer lock manager.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rwl_pkg;

	localparam int KIND_W    = 2;
	localparam int THREAD_W  = 4;
	localparam int STATUS_W  = 2;
	localparam int READERS_W = 5;
	localparam int DEPTH_W   = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ_LOCK    = 2'd0,
		KIND_WRITE_LOCK   = 2'd1,
		KIND_READ_UNLOCK  = 2'd2,
		KIND_WRITE_UNLOCK = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_WAIT    = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

endpackage

`default_nettype wire

/* rtl/rwl_req_if.sv */
// Request channel (valid/ready) of the lock manager: lock kind and thread.
// Depends on rwl_pkg.
`default_nettype none

interface rwl_req_if;
	logic                              valid;
	logic                              ready;
	rwl_pkg::kind_t                    kind;
	logic [rwl_pkg::THREAD_W-1:0]      thread;

	modport source (output valid, output kind, output thread, input ready);
	modport sink   (input valid, input kind, input thread, output ready);
endinterface

`default_nettype wire

/* rtl/rwl_rsp_if.sv */
// Response channel (valid/ready) of the lock manager: status and lock counts.
// Depends on rwl_pkg.
`default_nettype none

interface rwl_rsp_if;
	logic                              valid;
	logic                              ready;
	rwl_pkg::status_t                  status;
	logic [rwl_pkg::READERS_W-1:0]     readers_holding;
	logic [rwl_pkg::DEPTH_W-1:0]       write_depth;

	modport source (output valid, output status, output readers_holding,
		output write_depth, input ready);
	modport sink   (input valid, input status, input readers_holding,
		input write_depth, output ready);
endinterface

`default_nettype wire

/* rtl/rwl_ctrl.sv */
// Controller of the lock manager: request handshake, evaluate step and the
// response valid flag. Depends on rwl_pkg.
`default_nettype none

module rwl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rwl_pkg::ctl_cmd_t      cmd
);
	import rwl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_ready   = (state_q == S_IDLE);
	assign cmd.capture = req_valid && req_ready;
	// Commit only when the response slot is free or drains this cycle.
	assign cmd.commit  = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/rwl_datapath.sv */
// Datapath of the lock manager: per-thread read counts, pending writers,
// write owner and nesting, and the response word register. Depends on rwl_pkg.
`default_nettype none

module rwl_datapath #(
	parameter int THREADS    = 16,
	parameter int COUNT_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rwl_pkg::ctl_cmd_t                 cmd,
	input  wire rwl_pkg::kind_t                    kind,
	input  wire logic [rwl_pkg::THREAD_W-1:0]      thread,
	output rwl_pkg::status_t                       status,
	output logic [rwl_pkg::READERS_W-1:0]          readers_holding,
	output logic [rwl_pkg::DEPTH_W-1:0]            write_depth
);
	import rwl_pkg::*;

	localparam int TW = $clog2(THREADS);
	localparam int XW = (TW > THREAD_W) ? TW : THREAD_W;
	localparam int RW = $clog2(THREADS + 1);

	// Request held for the evaluate step
	kind_t                 kind_s1;
	logic [THREAD_W-1:0]   thread_s1;
	logic [TW-1:0]         idx_s1;
	logic                  in_range_s1;
	logic [COUNT_BITS-1:0] hold_s1;

	// Lock state
	logic [COUNT_BITS-1:0] hold_q [THREADS];
	logic [THREADS-1:0]    pend_q;
	logic [RW-1:0]         total_q;
	logic [THREAD_W-1:0]   wid_q;
	logic                  wvalid_q;
	logic [COUNT_BITS-1:0] nest_q;

	// Response word
	status_t               status_q;
	logic [READERS_W-1:0]  readers_q;
	logic [DEPTH_W-1:0]    depth_q;

	logic [XW-1:0]         thr_x;
	logic [TW-1:0]         idx_in;
	logic                  in_range;

	assign thr_x    = XW'(thread);
	assign idx_in   = thr_x[TW-1:0];
	assign in_range = (32'(thread) < THREADS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1     <= kind;
			thread_s1   <= thread;
			idx_s1      <= idx_in;
			in_range_s1 <= in_range;
			hold_s1     <= in_range ? hold_q[idx_in] : '0;
		end
	end

	// Evaluate
	status_t               st;
	logic                  hold_we;
	logic [COUNT_BITS-1:0] hold_nx;
	logic                  pend_we;
	logic                  pend_nx;
	logic [RW-1:0]         total_nx;
	logic [THREAD_W-1:0]   wid_nx;
	logic                  wvalid_nx;
	logic [COUNT_BITS-1:0] nest_nx;
	logic                  hold_zero;
	logic                  hold_max;
	logic                  nest_max;
	logic                  owner;

	assign hold_zero = (hold_s1 == '0);
	assign hold_max  = &hold_s1;
	assign nest_max  = &nest_q;
	assign owner     = wvalid_q && (wid_q == thread_s1);

	always_comb begin
		st        = ST_REFUSED;
		hold_we   = 1'b0;
		hold_nx   = hold_s1;
		pend_we   = 1'b0;
		pend_nx   = 1'b0;
		total_nx  = total_q;
		wid_nx    = wid_q;
		wvalid_nx = wvalid_q;
		nest_nx   = nest_q;
		if (in_range_s1) begin
			unique case (kind_s1)
				KIND_READ_LOCK: begin
					if (wvalid_q || (|pend_q)) begin
						st = ST_WAIT;
					end else if (!hold_max) begin
						st      = ST_OK;
						hold_we = 1'b1;
						hold_nx = hold_s1 + 1'b1;
						if (hold_zero) begin
							total_nx = total_q + 1'b1;
						end
					end
				end
				KIND_WRITE_LOCK: begin
					if (owner) begin
						if (!nest_max) begin
							st      = ST_OK;
							nest_nx = nest_q + 1'b1;
						end
					end else if (wvalid_q || (total_q != '0)) begin
						st      = ST_WAIT;
						pend_we = 1'b1;
						pend_nx = 1'b1;
					end else begin
						st        = ST_OK;
						pend_we   = 1'b1;
						pend_nx   = 1'b0;
						wvalid_nx = 1'b1;
						wid_nx    = thread_s1;
						nest_nx   = COUNT_BITS'(1);
					end
				end
				KIND_READ_UNLOCK: begin
					if ((total_q != '0) && !hold_zero) begin
						st      = ST_OK;
						hold_we = 1'b1;
						hold_nx = hold_s1 - 1'b1;
						if (hold_s1 == COUNT_BITS'(1)) begin
							total_nx = total_q - 1'b1;
						end
					end
				end
				KIND_WRITE_UNLOCK: begin
					if (owner && (nest_q != '0)) begin
						st      = ST_OK;
						nest_nx = nest_q - 1'b1;
						if (nest_q == COUNT_BITS'(1)) begin
							wvalid_nx = 1'b0;
							wid_nx    = '0;
						end
					end
				end
				default: st = ST_REFUSED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				hold_q[i] <= '0;
			end
			pend_q   <= '0;
			total_q  <= '0;
			wid_q    <= '0;
			wvalid_q <= 1'b0;
			nest_q   <= '0;
		end else if (cmd.commit) begin
			if (hold_we) begin
				hold_q[idx_s1] <= hold_nx;
			end
			if (pend_we) begin
				pend_q[idx_s1] <= pend_nx;
			end
			total_q  <= total_nx;
			wid_q    <= wid_nx;
			wvalid_q <= wvalid_nx;
			nest_q   <= nest_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= st;
			readers_q <= READERS_W'(total_nx);
			depth_q   <= DEPTH_W'(nest_nx);
		end
	end

	assign status          = status_q;
	assign readers_holding = readers_q;
	assign write_depth     = depth_q;

endmodule

`default_nettype wire

/* rtl/reader_writer_lock_manager.sv */
// Reader-writer lock manager with writer preference, top level.
// Depends on rwl_pkg, rwl_req_if, rwl_rsp_if, rwl_ctrl and rwl_datapath.
//
// Usage:
//   req carries one lock request word: kind (read lock, write lock,
//   read unlock, write unlock) and the requesting thread. rsp returns one
//   word per request: status (granted/released, wait and retry, refused),
//   the number of threads holding a read lock and the write nesting depth.
//   A blocked lock is not queued; the thread retries the request later.
//   Timing: a request is taken in the idle state, evaluated against the
//   lock registers in the execute state once the response register is
//   free, and written to the response register when it commits.
//   One request is in flight at a time: the next is taken only after the
//   capture/evaluate sequence of the controller has committed the last.
//   Stall: a response waiting in the output register does not block the
//   next request from being accepted; its evaluation waits until the
//   response register is free.
//   Reset: all read counts, pending writers, the write owner and the
//   nesting depth clear at once; requests are taken right after reset.
`default_nettype none

module reader_writer_lock_manager #(
	parameter int THREADS    = 16,
	parameter int COUNT_BITS = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	rwl_req_if.sink        req,
	rwl_rsp_if.source      rsp
);
	import rwl_pkg::*;

	ctl_cmd_t cmd;

	rwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	rwl_datapath #(
		.THREADS    (THREADS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.kind            (req.kind),
		.thread          (req.thread),
		.status          (rsp.status),
		.readers_holding (rsp.readers_holding),
		.write_depth     (rsp.write_depth)
	);

endmodule

`default_nettype wire
